// File: src/ppsch_pkg.sv
// ----------------------------------------------------------------------------
// ppsch_pkg
// Shared constants and controller/datapath handshake types for the
// preemptive priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package ppsch_pkg;

   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = $clog2(MAX_TASKS);
   localparam int CLK_W     = 24;
   localparam int HALF_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int PH_W      = 3;
   localparam int TOT_W     = 18;
   localparam int SW_W      = 16;

   localparam logic       CMD_LOAD = 1'b0;
   localparam logic       CMD_TICK = 1'b1;
   localparam logic [1:0] STAGE_FIRST  = 2'd0;
   localparam logic [1:0] STAGE_SECOND = 2'd1;

   typedef struct packed {
      logic load;
      logic tick_start;
      logic scan_init;
      logic scan_step;
      logic decide;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic again;
   } dp_status_type;

endpackage
`default_nettype wire

// File: src/ppsch_ctrl.sv
// ----------------------------------------------------------------------------
// ppsch_ctrl
// Sequencer: accept a request; for a tick, scan the task table, decide, present the result.
// ----------------------------------------------------------------------------
`default_nettype none
module ppsch_ctrl
   import ppsch_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_cmd,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_DEC  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_TICK) begin
                  cmd.tick_start = 1'b1;
                  cmd.scan_init  = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) state_in = S_DEC;
         end
         S_DEC: begin
            cmd.decide = 1'b1;
            if (status.again) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule
`default_nettype wire

// File: src/ppsch_dp.sv
// ----------------------------------------------------------------------------
// ppsch_dp
// Task table, best-ready scan, burst/IO bookkeeping and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module ppsch_dp
   import ppsch_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   output dp_status_type           status,
   input  wire logic [BYTE_W-1:0]  req_task_id,
   input  wire logic [BYTE_W-1:0]  req_prio,
   input  wire logic [HALF_W-1:0]  req_arrive_at,
   input  wire logic [HALF_W-1:0]  req_first_burst,
   input  wire logic [HALF_W-1:0]  req_io_len,
   input  wire logic [HALF_W-1:0]  req_second_burst,
   output logic [CLK_W-1:0]        rsp_slot_time,
   output logic                    rsp_busy_res,
   output logic [BYTE_W-1:0]       rsp_run_id,
   output logic                    rsp_finished,
   output logic [BYTE_W-1:0]       rsp_fin_id,
   output logic [CLK_W-1:0]        rsp_completion,
   output logic [CLK_W-1:0]        rsp_turnaround,
   output logic [CLK_W-1:0]        rsp_waiting,
   output logic [CLK_W-1:0]        rsp_response,
   output logic [SW_W-1:0]         rsp_switch_count,
   output logic                    rsp_all_done
);

   logic [MAX_TASKS-1:0] valid_ff;
   logic [PH_W-1:0]      ph_ff   [MAX_TASKS];
   logic [BYTE_W-1:0]    id_ff   [MAX_TASKS];
   logic [BYTE_W-1:0]    prio_ff [MAX_TASKS];
   logic [HALF_W-1:0]    arr_ff  [MAX_TASKS];
   logic [CLK_W-1:0]     rdy_ff  [MAX_TASKS];
   logic [HALF_W-1:0]    left_ff [MAX_TASKS];
   logic [HALF_W-1:0]    io_ff   [MAX_TASKS];
   logic [HALF_W-1:0]    sec_ff  [MAX_TASKS];
   logic [TOT_W-1:0]     tot_ff  [MAX_TASKS];
   logic [CLK_W-1:0]     st_ff   [MAX_TASKS];

   logic [CLK_W-1:0]  now_ff;
   logic              lr_ok_ff;
   logic [IDX_W-1:0]  lr_idx_ff;
   logic [SW_W-1:0]   sw_ff;
   logic              first_ff;
   logic [IDX_W-1:0]  scan_idx_ff;
   logic              best_ok_ff;
   logic [IDX_W-1:0]  best_ff;
   logic [BYTE_W-1:0] bprio_ff;
   logic [BYTE_W-1:0] bid_ff;

   logic [CLK_W-1:0]  slot_time_ff, comp_ff, turn_ff, wait_ff, resp_ff;
   logic              busy_ff, fin_ff;
   logic [BYTE_W-1:0] run_id_ff, fin_id_ff;

   // free slot search
   logic             has_free;
   logic [IDX_W-1:0] free_idx;
   always_comb begin
      has_free = 1'b0;
      free_idx = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            has_free = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // single read port
   logic [IDX_W-1:0]  ra;
   logic              r_valid;
   logic [PH_W-1:0]   r_ph;
   logic [BYTE_W-1:0] r_id, r_prio;
   logic [HALF_W-1:0] r_arr, r_left, r_io, r_sec;
   logic [CLK_W-1:0]  r_rdy, r_st;
   logic [TOT_W-1:0]  r_tot;
   assign ra      = cmd.decide ? best_ff : scan_idx_ff;
   assign r_valid = valid_ff[ra];
   assign r_ph    = ph_ff[ra];
   assign r_id    = id_ff[ra];
   assign r_prio  = prio_ff[ra];
   assign r_arr   = arr_ff[ra];
   assign r_rdy   = rdy_ff[ra];
   assign r_left  = left_ff[ra];
   assign r_io    = io_ff[ra];
   assign r_sec   = sec_ff[ra];
   assign r_tot   = tot_ff[ra];
   assign r_st    = st_ff[ra];

   logic is_ready, is_better;
   assign is_ready  = r_valid && (r_rdy <= now_ff);
   assign is_better = !best_ok_ff || (r_prio < bprio_ff) ||
                      ((r_prio == bprio_ff) && (r_id < bid_ff));

   // decide-cycle arithmetic
   logic [CLK_W-1:0] now_inc, when_c, st_eff, turn_c;
   logic             stage0, zero_left;
   assign now_inc   = now_ff + CLK_W'(1);
   assign zero_left = (r_left == '0);
   assign stage0    = (r_ph[1:0] == STAGE_FIRST);
   assign when_c    = zero_left ? now_ff : now_inc;
   assign st_eff    = r_ph[2] ? r_st : now_ff;
   assign turn_c    = when_c - CLK_W'(r_arr);

   assign status.scan_last = (scan_idx_ff == IDX_W'(MAX_TASKS - 1));
   assign status.again     = best_ok_ff && zero_left && stage0;

   always_ff @(posedge clock) begin
      if (cmd.load && has_free) begin
         ph_ff[free_idx]   <= '0;
         id_ff[free_idx]   <= req_task_id;
         prio_ff[free_idx] <= req_prio;
         arr_ff[free_idx]  <= req_arrive_at;
         rdy_ff[free_idx]  <= CLK_W'(req_arrive_at);
         left_ff[free_idx] <= req_first_burst;
         io_ff[free_idx]   <= req_io_len;
         sec_ff[free_idx]  <= req_second_burst;
         tot_ff[free_idx]  <= TOT_W'(req_first_burst) + TOT_W'(req_io_len)
                              + TOT_W'(req_second_burst);
         st_ff[free_idx]   <= '0;
      end
      if (cmd.decide && best_ok_ff) begin
         if (!r_ph[2]) st_ff[best_ff] <= now_ff;
         if (zero_left) begin
            if (stage0) begin
               ph_ff[best_ff]   <= {1'b1, STAGE_SECOND};
               left_ff[best_ff] <= r_sec;
               rdy_ff[best_ff]  <= now_ff + CLK_W'(r_io);
            end else begin
               ph_ff[best_ff] <= {1'b1, r_ph[1:0]};
            end
         end else if (r_left == HALF_W'(1) && stage0) begin
            ph_ff[best_ff]   <= {1'b1, STAGE_SECOND};
            left_ff[best_ff] <= r_sec;
            rdy_ff[best_ff]  <= now_inc + CLK_W'(r_io);
         end else begin
            ph_ff[best_ff]   <= {1'b1, r_ph[1:0]};
            left_ff[best_ff] <= r_left - HALF_W'(1);
         end
      end
   end

   logic do_finish;
   assign do_finish = best_ok_ff && !stage0 &&
                      (zero_left || (r_left == HALF_W'(1)));

   always_ff @(posedge clock) begin
      if (cmd.tick_start) begin
         slot_time_ff <= now_ff;
         busy_ff      <= 1'b0;
         run_id_ff    <= '0;
         fin_ff       <= 1'b0;
         fin_id_ff    <= '0;
         comp_ff      <= '0;
         turn_ff      <= '0;
         wait_ff      <= '0;
         resp_ff      <= '0;
      end else if (cmd.decide) begin
         if (best_ok_ff && !zero_left) begin
            busy_ff   <= 1'b1;
            run_id_ff <= r_id;
         end
         if (do_finish) begin
            fin_ff    <= 1'b1;
            fin_id_ff <= r_id;
            comp_ff   <= when_c;
            turn_ff   <= turn_c;
            wait_ff   <= turn_c - CLK_W'(r_tot);
            resp_ff   <= st_eff - CLK_W'(r_arr);
         end
      end
      if (cmd.scan_init) begin
         scan_idx_ff <= '0;
         best_ok_ff  <= 1'b0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         if (is_ready && is_better) begin
            best_ok_ff <= 1'b1;
            best_ff    <= scan_idx_ff;
            bprio_ff   <= r_prio;
            bid_ff     <= r_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         now_ff   <= '0;
         lr_ok_ff <= 1'b0;
         sw_ff    <= '0;
         first_ff <= 1'b0;
      end else begin
         if (cmd.load && has_free) valid_ff[free_idx] <= 1'b1;
         if (cmd.tick_start) first_ff <= 1'b1;
         if (cmd.decide) begin
            first_ff <= 1'b0;
            lr_ok_ff <= best_ok_ff && !zero_left && (r_left != HALF_W'(1));
            if (first_ff && lr_ok_ff && (!best_ok_ff || best_ff != lr_idx_ff) &&
                sw_ff != '1)
               sw_ff <= sw_ff + SW_W'(1);
            if (!best_ok_ff) begin
               now_ff <= now_inc;
            end else if (!zero_left) begin
               now_ff <= now_inc;
               if (r_left != HALF_W'(1)) lr_idx_ff <= best_ff;
            end
            if (do_finish) valid_ff[best_ff] <= 1'b0;
         end
      end
   end

   assign rsp_slot_time    = slot_time_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_run_id       = run_id_ff;
   assign rsp_finished     = fin_ff;
   assign rsp_fin_id       = fin_id_ff;
   assign rsp_completion   = comp_ff;
   assign rsp_turnaround   = turn_ff;
   assign rsp_waiting      = wait_ff;
   assign rsp_response     = resp_ff;
   assign rsp_switch_count = sw_ff;
   assign rsp_all_done     = ~|valid_ff;

endmodule
`default_nettype wire

// File: src/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Preemptive priority scheduler with a sixteen-entry task table.
// ----------------------------------------------------------------------------
// A load transaction (cmd 0) stores a task in the lowest free slot and
// returns nothing. A tick transaction (cmd 1) returns one result after a
// scan of the table, one slot per cycle, followed by a decision step; the
// scan and decision repeat for each task that finishes a zero-length first
// burst in that tick. The block takes a new transaction once the result
// is taken.
`default_nettype none
module preemptive_priority_scheduler
   import ppsch_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_cmd,
   input  wire logic [BYTE_W-1:0] req_task_id,
   input  wire logic [BYTE_W-1:0] req_prio,
   input  wire logic [HALF_W-1:0] req_arrive_at,
   input  wire logic [HALF_W-1:0] req_first_burst,
   input  wire logic [HALF_W-1:0] req_io_len,
   input  wire logic [HALF_W-1:0] req_second_burst,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [CLK_W-1:0]       rsp_slot_time,
   output logic                   rsp_busy_res,
   output logic [BYTE_W-1:0]      rsp_run_id,
   output logic                   rsp_finished,
   output logic [BYTE_W-1:0]      rsp_fin_id,
   output logic [CLK_W-1:0]       rsp_completion,
   output logic [CLK_W-1:0]       rsp_turnaround,
   output logic [CLK_W-1:0]       rsp_waiting,
   output logic [CLK_W-1:0]       rsp_response,
   output logic [SW_W-1:0]        rsp_switch_count,
   output logic                   rsp_all_done
);

   dp_cmd_type    cmd;
   dp_status_type status;

   ppsch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ppsch_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_task_id      (req_task_id),
      .req_prio         (req_prio),
      .req_arrive_at    (req_arrive_at),
      .req_first_burst  (req_first_burst),
      .req_io_len       (req_io_len),
      .req_second_burst (req_second_burst),
      .rsp_slot_time    (rsp_slot_time),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_run_id       (rsp_run_id),
      .rsp_finished     (rsp_finished),
      .rsp_fin_id       (rsp_fin_id),
      .rsp_completion   (rsp_completion),
      .rsp_turnaround   (rsp_turnaround),
      .rsp_waiting      (rsp_waiting),
      .rsp_response     (rsp_response),
      .rsp_switch_count (rsp_switch_count),
      .rsp_all_done     (rsp_all_done)
   );

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the preemptive priority scheduler against a predictor of its task
// table. Task loads and time ticks go in over a valid/ready channel. Every
// tick result is compared field by field with the predicted one. The tests
// cover directed special cases, a table overflow under a long result
// hold-off, and random traffic with varied sender and receiver idling.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
   import ppsch_pkg::*;

   localparam int NONE_SLOT = MAX_TASKS;
   localparam int DRAIN_CYCLES = 400;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct packed {
      logic [CLK_W-1:0]  slot_time;
      logic              busy_res;
      logic [BYTE_W-1:0] run_id;
      logic              finished;
      logic [BYTE_W-1:0] fin_id;
      logic [CLK_W-1:0]  completion;
      logic [CLK_W-1:0]  turnaround;
      logic [CLK_W-1:0]  waiting;
      logic [CLK_W-1:0]  response;
      logic [SW_W-1:0]   switch_count;
      logic              all_done;
   } tick_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_cmd = CMD_LOAD;
   logic [BYTE_W-1:0] req_task_id = '0;
   logic [BYTE_W-1:0] req_prio = '0;
   logic [HALF_W-1:0] req_arrive_at = '0;
   logic [HALF_W-1:0] req_first_burst = '0;
   logic [HALF_W-1:0] req_io_len = '0;
   logic [HALF_W-1:0] req_second_burst = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [CLK_W-1:0] rsp_slot_time;
   logic rsp_busy_res;
   logic [BYTE_W-1:0] rsp_run_id;
   logic rsp_finished;
   logic [BYTE_W-1:0] rsp_fin_id;
   logic [CLK_W-1:0] rsp_completion;
   logic [CLK_W-1:0] rsp_turnaround;
   logic [CLK_W-1:0] rsp_waiting;
   logic [CLK_W-1:0] rsp_response;
   logic [SW_W-1:0] rsp_switch_count;
   logic rsp_all_done;

   preemptive_priority_scheduler DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_task_id(req_task_id), .req_prio(req_prio),
      .req_arrive_at(req_arrive_at), .req_first_burst(req_first_burst),
      .req_io_len(req_io_len), .req_second_burst(req_second_burst),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_slot_time(rsp_slot_time), .rsp_busy_res(rsp_busy_res),
      .rsp_run_id(rsp_run_id), .rsp_finished(rsp_finished),
      .rsp_fin_id(rsp_fin_id), .rsp_completion(rsp_completion),
      .rsp_turnaround(rsp_turnaround), .rsp_waiting(rsp_waiting),
      .rsp_response(rsp_response), .rsp_switch_count(rsp_switch_count),
      .rsp_all_done(rsp_all_done)
   );

   always #2 clock = ~clock;

   // scheduler table mirror
   logic              tbl_used [MAX_TASKS];
   logic              tbl_second_stage [MAX_TASKS];
   logic              tbl_started [MAX_TASKS];
   logic [BYTE_W-1:0] tbl_id [MAX_TASKS];
   logic [BYTE_W-1:0] tbl_prio [MAX_TASKS];
   logic [CLK_W-1:0]  tbl_arrival [MAX_TASKS];
   logic [CLK_W-1:0]  tbl_ready_at [MAX_TASKS];
   logic [HALF_W-1:0] tbl_left [MAX_TASKS];
   logic [HALF_W-1:0] tbl_io [MAX_TASKS];
   logic [HALF_W-1:0] tbl_second [MAX_TASKS];
   logic [TOT_W-1:0]  tbl_total [MAX_TASKS];
   logic [CLK_W-1:0]  tbl_start [MAX_TASKS];
   logic [CLK_W-1:0]  sched_now;
   int                prev_runner;
   logic [SW_W-1:0]   switch_total;

   tick_result_type pending_results[$];
   int mismatches = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   function automatic int best_ready_slot();
      int b;
      b = NONE_SLOT;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (!tbl_used[i] || tbl_ready_at[i] > sched_now) continue;
         if (b == NONE_SLOT || tbl_prio[i] < tbl_prio[b] ||
             (tbl_prio[i] == tbl_prio[b] && tbl_id[i] < tbl_id[b]))
            b = i;
      end
      return b;
   endfunction

   function automatic logic table_empty();
      for (int i = 0; i < MAX_TASKS; i++)
         if (tbl_used[i]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic start_io(input int s, input logic [CLK_W-1:0] at);
      tbl_second_stage[s] = 1'b1;
      tbl_left[s] = tbl_second[s];
      tbl_ready_at[s] = at + CLK_W'(tbl_io[s]);
   endtask

   task automatic retire_task(input int s, input logic [CLK_W-1:0] at,
                              inout tick_result_type r);
      r.finished = 1'b1;
      r.fin_id = tbl_id[s];
      r.completion = at;
      r.turnaround = at - tbl_arrival[s];
      r.waiting = r.turnaround - CLK_W'(tbl_total[s]);
      r.response = tbl_start[s] - tbl_arrival[s];
      tbl_used[s] = 1'b0;
   endtask

   task automatic load_task(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] pr,
                            input logic [HALF_W-1:0] arr, input logic [HALF_W-1:0] fb,
                            input logic [HALF_W-1:0] io, input logic [HALF_W-1:0] sb);
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (!tbl_used[i]) begin
            tbl_used[i] = 1'b1;
            tbl_second_stage[i] = 1'b0;
            tbl_started[i] = 1'b0;
            tbl_id[i] = id;
            tbl_prio[i] = pr;
            tbl_arrival[i] = CLK_W'(arr);
            tbl_ready_at[i] = CLK_W'(arr);
            tbl_left[i] = fb;
            tbl_io[i] = io;
            tbl_second[i] = sb;
            tbl_total[i] = TOT_W'(fb) + TOT_W'(io) + TOT_W'(sb);
            tbl_start[i] = '0;
            break;
         end
      end
   endtask

   task automatic advance_clock(output tick_result_type r);
      int b;
      logic ended;
      r = '0;
      ended = 1'b0;
      r.slot_time = sched_now;
      b = best_ready_slot();
      if (prev_runner != NONE_SLOT && b != prev_runner && switch_total != 16'hFFFF)
         switch_total++;
      prev_runner = NONE_SLOT;
      for (int iter = 0; iter < 2 * MAX_TASKS + 2; iter++) begin
         b = best_ready_slot();
         if (b == NONE_SLOT) break;
         if (!tbl_started[b]) begin
            tbl_start[b] = sched_now;
            tbl_started[b] = 1'b1;
         end
         if (tbl_left[b] == 0) begin
            if (!tbl_second_stage[b]) begin
               start_io(b, sched_now);
               continue;
            end
            retire_task(b, sched_now, r);
            ended = 1'b1;
            break;
         end
         tbl_left[b]--;
         r.busy_res = 1'b1;
         r.run_id = tbl_id[b];
         if (tbl_left[b] == 0) begin
            if (!tbl_second_stage[b]) start_io(b, sched_now + CLK_W'(1));
            else retire_task(b, sched_now + CLK_W'(1), r);
         end else begin
            prev_runner = b;
         end
         break;
      end
      if (!ended) sched_now = sched_now + CLK_W'(1);
      r.switch_count = switch_total;
      r.all_done = table_empty();
   endtask

   task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] id,
                            input logic [BYTE_W-1:0] pr, input logic [HALF_W-1:0] arr,
                            input logic [HALF_W-1:0] fb, input logic [HALF_W-1:0] io,
                            input logic [HALF_W-1:0] sb);
      tick_result_type r;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_task_id <= id;
      req_prio <= pr;
      req_arrive_at <= arr;
      req_first_burst <= fb;
      req_io_len <= io;
      req_second_burst <= sb;
      do @(posedge clock); while (!req_ready);
      if (cmd == CMD_LOAD) begin
         load_task(id, pr, arr, fb, io, sb);
      end else begin
         advance_clock(r);
         pending_results = {pending_results, r};
      end
   endtask

   task automatic send_tick();
      send_item(CMD_TICK, BYTE_W'($urandom), BYTE_W'($urandom), HALF_W'($urandom),
                HALF_W'($urandom), HALF_W'($urandom), HALF_W'($urandom));
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      logic rdy;
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rdy = 1'b0;
      end else begin
         rdy = ($urandom_range(0, 99) >= stall_pct);
      end
      rsp_ready <= rdy;
   end

   always @(posedge clock) begin
      tick_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 32'd1, 32'd0);
         end else begin
            e = pending_results.pop_front();
            if (rsp_slot_time !== e.slot_time)
               report_mismatch("slot_time", rsp_slot_time, e.slot_time);
            if (rsp_busy_res !== e.busy_res)
               report_mismatch("busy_res", rsp_busy_res, e.busy_res);
            if (rsp_run_id !== e.run_id) report_mismatch("run_id", rsp_run_id, e.run_id);
            if (rsp_finished !== e.finished)
               report_mismatch("finished", rsp_finished, e.finished);
            if (rsp_fin_id !== e.fin_id) report_mismatch("fin_id", rsp_fin_id, e.fin_id);
            if (rsp_completion !== e.completion)
               report_mismatch("completion", rsp_completion, e.completion);
            if (rsp_turnaround !== e.turnaround)
               report_mismatch("turnaround", rsp_turnaround, e.turnaround);
            if (rsp_waiting !== e.waiting)
               report_mismatch("waiting", rsp_waiting, e.waiting);
            if (rsp_response !== e.response)
               report_mismatch("response", rsp_response, e.response);
            if (rsp_switch_count !== e.switch_count)
               report_mismatch("switch_count", rsp_switch_count, e.switch_count);
            if (rsp_all_done !== e.all_done)
               report_mismatch("all_done", rsp_all_done, e.all_done);
         end
      end
   end

   task automatic test_directed();
      send_tick();
      // tie on priority, zero I/O, zero second burst, zero first burst
      send_item(CMD_LOAD, 8'd5, 8'd3, 16'd0, 16'd2, 16'd0, 16'd1);
      send_item(CMD_LOAD, 8'd2, 8'd3, 16'd1, 16'd1, 16'd2, 16'd0);
      send_item(CMD_LOAD, 8'd9, 8'd0, 16'd2, 16'd0, 16'd1, 16'd1);
      send_item(CMD_LOAD, 8'd5, 8'd3, 16'd0, 16'd1, 16'd0, 16'd1);
      repeat (3) send_tick();
      // late arrival
      send_item(CMD_LOAD, 8'd7, 8'd1, 16'd0, 16'd2, 16'd0, 16'd1);
      repeat (8) send_tick();
      send_item(CMD_LOAD, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(CMD_LOAD, 8'd0, 8'd0, 16'd0, 16'd2, 16'hFFFF, 16'd3);
      repeat (4) send_tick();
      wait_results_drained();
   endtask

   task automatic test_table_full_under_hold();
      logic [HALF_W-1:0] base;
      hold_request = 400;
      base = HALF_W'(sched_now) + 16'd20;
      for (int i = 0; i < MAX_TASKS + 2; i++)
         send_item(CMD_LOAD, 8'(i + 40), 8'($urandom_range(0, 3)), base, 16'd1, 16'd0, 16'd0);
      repeat (30) send_tick();
      wait_results_drained();
   endtask

   task automatic test_random(input int items, input int idle, input int stall);
      logic [HALF_W-1:0] arr;
      logic [BYTE_W-1:0] pr;
      send_idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(0, 99) < 40) begin
            arr = HALF_W'(sched_now) + HALF_W'($urandom_range(0, 6));
            if ($urandom_range(0, 9) == 0 && sched_now >= 6)
               arr = HALF_W'(sched_now) - HALF_W'($urandom_range(1, 5));
            pr = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            send_item(CMD_LOAD, BYTE_W'($urandom), pr, arr, HALF_W'($urandom_range(0, 4)),
                      HALF_W'($urandom_range(0, 4)), HALF_W'($urandom_range(0, 3)));
         end else begin
            send_tick();
         end
      end
      wait_results_drained();
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      for (int i = 0; i < MAX_TASKS; i++) tbl_used[i] = 1'b0;
      sched_now = '0;
      prev_runner = NONE_SLOT;
      switch_total = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full_under_hold();
      test_random(145, 0, 0);
      test_random(145, 52, 0);
      test_random(145, 0, 52);
      test_random(145, 8, 8);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: sim.f
src/ppsch_pkg.sv
src/ppsch_ctrl.sv
src/ppsch_dp.sv
src/preemptive_priority_scheduler.sv
tb/tb_top.sv
